### hdl/autoranging_histogram_defines.svh
// Assertion macros used by the verification checker of the histogram block.
`ifndef AUTORANGING_HISTOGRAM_DEFINES_SVH
`define AUTORANGING_HISTOGRAM_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define AH_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define AH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/ahist_pkg.sv
// Package of the auto-ranging histogram: types, codes and reset constants.
`default_nettype none

package ahist_pkg;

  // Default sizes of the bin store and the history store.
  localparam int MAX_BINS_DEF   = 64;
  localparam int TUNE_DEPTH_DEF = 8192;

  // Fixed field widths.
  localparam int BIN_IDX_W = 6;
  localparam int DIV_W     = 33;

  // Register values after reset.
  localparam int RST_BUCKETS = 30;
  localparam int RST_TUNE    = 5000;
  localparam int RST_LOWER   = 0;
  localparam int RST_UPPER   = 1;

  // Operation codes of an input word.
  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_DUMP  = 2'd2;

  // Register indexes of the configuration port.
  localparam logic [1:0] REG_BUCKETS = 2'd0;
  localparam logic [1:0] REG_TUNE    = 2'd1;
  localparam logic [1:0] REG_LOWER   = 2'd2;
  localparam logic [1:0] REG_UPPER   = 2'd3;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [31:0] sample;
  } in_word_t;

  typedef struct packed {
    logic [5:0]         bin_index;
    logic [31:0]        bin_hits;
    logic [31:0]        below_hits;
    logic [31:0]        above_hits;
    logic signed [31:0] least_seen;
    logic signed [31:0] most_seen;
    logic signed [63:0] sample_total;
    logic [31:0]        sample_tally;
    logic signed [31:0] range_base;
    logic [32:0]        bin_span;
    logic               tuning_active;
    logic               last_item;
  } out_word_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CFG,
    S_DECIDE,
    S_BOUNDS,
    S_HIST_RD,
    S_HIST_LD,
    S_CLASSIFY,
    S_DIVIDE,
    S_BIN_RD,
    S_BIN_WR,
    S_DUMP_RD,
    S_DUMP_EMIT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;
    logic reinit;
    logic bnd_start_cfg;
    logic bnd_start_tune;
    logic bnd_load;
    logic hist_first;
    logic hist_next;
    logic load_v_hist;
    logic div_start_bin;
    logic below_inc;
    logic above_inc;
    logic addr_zero;
    logic addr_q;
    logic bin_write;
    logic dump_first;
    logic emit;
    logic bins_clear;
    logic tune_end;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] op;
    logic       tuning;
    logic       tune_hit;
    logic       hist_empty;
    logic       hist_last;
    logic       off_neg;
    logic       neg_below;
    logic       div_done;
    logic       q_over;
    logic       dump_last;
    logic       out_free;
  } stat_t;

endpackage

`default_nettype wire

### hdl/ahist_ram.sv
// Generic one-write, one-read RAM with registered read data.
`default_nettype none

module ahist_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

### hdl/ahist_div.sv
// Serial restoring divider, one quotient bit per cycle.
`default_nettype none

module ahist_div (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic [ahist_pkg::DIV_W-1:0]  dividend,
  input  wire logic [ahist_pkg::DIV_W-1:0]  divisor,
  output logic                              done,
  output logic      [ahist_pkg::DIV_W-1:0]  quotient
);

  localparam int W  = ahist_pkg::DIV_W;
  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  rem_r, rem_nxt;
  logic [W-1:0]  quo_r, quo_nxt;
  logic [W-1:0]  dvs_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;
  logic [W:0]    shifted;
  logic [W:0]    diff;

  // One trial subtraction per cycle.
  always_comb begin
    shifted = {rem_r, quo_r[W-1]};
    diff    = shifted - {1'b0, dvs_r};
    if (!diff[W]) begin
      rem_nxt = diff[W-1:0];
      quo_nxt = {quo_r[W-2:0], 1'b1};
    end else begin
      rem_nxt = shifted[W-1:0];
      quo_nxt = {quo_r[W-2:0], 1'b0};
    end
  end

  // Iteration control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Operand and partial result registers.
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

### hdl/ahist_ctrl.sv
// Controller state machine of the histogram: sequences binning, ranging and dumps.
`default_nettype none

module ahist_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  input  wire logic [1:0]       in_op,
  input  wire logic             cfg_valid,
  input  wire ahist_pkg::stat_t stat,
  output logic                  in_stall,
  output logic                  cfg_ready,
  output ahist_pkg::cmd_t       cmd
);

  ahist_pkg::state_t state_r, state_nxt;
  logic hist_mode_r, hist_mode_nxt;
  logic dump_mode_r, dump_mode_nxt;
  logic take;
  logic bin_done;
  logic finish;

  // Shared decode of the handshake and of the end of one binning.
  assign take = (state_r == ahist_pkg::S_IDLE) && in_valid && !cfg_valid;
  assign bin_done = ((state_r == ahist_pkg::S_CLASSIFY) && stat.off_neg && stat.neg_below)
                 || ((state_r == ahist_pkg::S_DIVIDE) && stat.div_done && stat.q_over)
                 || (state_r == ahist_pkg::S_BIN_WR);
  assign finish = (bin_done && hist_mode_r && stat.hist_last)
               || ((state_r == ahist_pkg::S_BOUNDS) && stat.div_done && hist_mode_r
                   && stat.hist_empty);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ahist_pkg::S_IDLE: begin
        if (cfg_valid) begin
          state_nxt = ahist_pkg::S_CFG;
        end else if (in_valid && (in_op == ahist_pkg::OP_ADD || in_op == ahist_pkg::OP_DUMP)) begin
          state_nxt = ahist_pkg::S_DECIDE;
        end
      end
      ahist_pkg::S_CFG: state_nxt = ahist_pkg::S_BOUNDS;
      ahist_pkg::S_DECIDE: begin
        if (stat.op == ahist_pkg::OP_ADD) begin
          if (!stat.tuning) begin
            state_nxt = ahist_pkg::S_CLASSIFY;
          end else if (stat.tune_hit) begin
            state_nxt = ahist_pkg::S_BOUNDS;
          end else begin
            state_nxt = ahist_pkg::S_IDLE;
          end
        end else if (stat.tuning) begin
          state_nxt = ahist_pkg::S_BOUNDS;
        end else begin
          state_nxt = ahist_pkg::S_DUMP_RD;
        end
      end
      ahist_pkg::S_BOUNDS: begin
        if (stat.div_done) begin
          if (!hist_mode_r) begin
            state_nxt = ahist_pkg::S_IDLE;
          end else if (stat.hist_empty) begin
            state_nxt = dump_mode_r ? ahist_pkg::S_DUMP_RD : ahist_pkg::S_IDLE;
          end else begin
            state_nxt = ahist_pkg::S_HIST_RD;
          end
        end
      end
      ahist_pkg::S_HIST_RD: state_nxt = ahist_pkg::S_HIST_LD;
      ahist_pkg::S_HIST_LD: state_nxt = ahist_pkg::S_CLASSIFY;
      ahist_pkg::S_CLASSIFY: begin
        if (!stat.off_neg) begin
          state_nxt = ahist_pkg::S_DIVIDE;
        end else if (!stat.neg_below) begin
          state_nxt = ahist_pkg::S_BIN_RD;
        end
      end
      ahist_pkg::S_DIVIDE: begin
        if (stat.div_done && !stat.q_over) begin
          state_nxt = ahist_pkg::S_BIN_RD;
        end
      end
      ahist_pkg::S_BIN_RD: state_nxt = ahist_pkg::S_BIN_WR;
      ahist_pkg::S_BIN_WR: state_nxt = ahist_pkg::S_IDLE;
      ahist_pkg::S_DUMP_RD: state_nxt = ahist_pkg::S_DUMP_EMIT;
      ahist_pkg::S_DUMP_EMIT: begin
        if (stat.out_free) begin
          state_nxt = stat.dump_last ? ahist_pkg::S_IDLE : ahist_pkg::S_DUMP_RD;
        end
      end
      default: state_nxt = ahist_pkg::S_IDLE;
    endcase
    // The end of a binning returns to idle, goes on with the history walk or finishes it.
    if (bin_done) begin
      if (!hist_mode_r) begin
        state_nxt = ahist_pkg::S_IDLE;
      end else if (!stat.hist_last) begin
        state_nxt = ahist_pkg::S_HIST_RD;
      end else begin
        state_nxt = dump_mode_r ? ahist_pkg::S_DUMP_RD : ahist_pkg::S_IDLE;
      end
    end
  end

  // Commands and mode flags.
  always_comb begin
    cmd           = '0;
    hist_mode_nxt = hist_mode_r;
    dump_mode_nxt = dump_mode_r;
    in_stall      = (state_r != ahist_pkg::S_IDLE) || cfg_valid;
    cfg_ready     = (state_r == ahist_pkg::S_IDLE);
    cmd.take      = take;
    unique case (state_r)
      ahist_pkg::S_CFG: begin
        cmd.reinit        = 1'b1;
        cmd.bnd_start_cfg = 1'b1;
        hist_mode_nxt     = 1'b0;
        dump_mode_nxt     = 1'b0;
      end
      ahist_pkg::S_DECIDE: begin
        hist_mode_nxt = 1'b0;
        dump_mode_nxt = (stat.op == ahist_pkg::OP_DUMP);
        if (stat.tuning && (stat.op == ahist_pkg::OP_DUMP || stat.tune_hit)) begin
          cmd.bnd_start_tune = 1'b1;
          hist_mode_nxt      = 1'b1;
        end else if (!stat.tuning && stat.op == ahist_pkg::OP_DUMP) begin
          cmd.dump_first = 1'b1;
        end
      end
      ahist_pkg::S_BOUNDS: begin
        if (stat.div_done) begin
          cmd.bnd_load   = 1'b1;
          cmd.hist_first = hist_mode_r;
        end
      end
      ahist_pkg::S_HIST_LD: cmd.load_v_hist = 1'b1;
      ahist_pkg::S_CLASSIFY: begin
        if (!stat.off_neg) begin
          cmd.div_start_bin = 1'b1;
        end else if (stat.neg_below) begin
          cmd.below_inc = 1'b1;
        end else begin
          cmd.addr_zero = 1'b1;
        end
      end
      ahist_pkg::S_DIVIDE: begin
        if (stat.div_done) begin
          cmd.above_inc = stat.q_over;
          cmd.addr_q    = !stat.q_over;
        end
      end
      ahist_pkg::S_BIN_WR: cmd.bin_write = 1'b1;
      ahist_pkg::S_DUMP_EMIT: begin
        if (stat.out_free) begin
          cmd.emit       = 1'b1;
          cmd.bins_clear = stat.dump_last && stat.tuning;
        end
      end
      default: ;
    endcase
    // Walk on through the history, or close the walk.
    cmd.hist_next = bin_done && hist_mode_r && !stat.hist_last;
    if (finish) begin
      cmd.dump_first = dump_mode_r;
      cmd.tune_end   = !dump_mode_r;
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ahist_pkg::S_IDLE;
      hist_mode_r <= 1'b0;
      dump_mode_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      hist_mode_r <= hist_mode_nxt;
      dump_mode_r <= dump_mode_nxt;
    end
  end

endmodule

`default_nettype wire

### hdl/ahist_dp.sv
// Datapath of the histogram: statistics, bounds, bin and history stores, result register.
`default_nettype none

module ahist_dp #(
  parameter int MAX_BINS   = ahist_pkg::MAX_BINS_DEF,
  parameter int TUNE_DEPTH = ahist_pkg::TUNE_DEPTH_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire ahist_pkg::in_word_t  in_data,
  input  wire logic                 cfg_we,
  input  wire logic [1:0]           cfg_index,
  input  wire logic [31:0]          cfg_data,
  input  wire ahist_pkg::cmd_t      cmd,
  output ahist_pkg::stat_t          stat,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output ahist_pkg::out_word_t      out_data
);

  localparam int BAW = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
  localparam int HAW = (TUNE_DEPTH > 1) ? $clog2(TUNE_DEPTH) : 1;
  localparam int RST_BINS = (ahist_pkg::RST_BUCKETS > MAX_BINS) ? MAX_BINS
                                                                : ahist_pkg::RST_BUCKETS;
  localparam int RST_WIDTH = (ahist_pkg::RST_UPPER - ahist_pkg::RST_LOWER) / RST_BINS + 1;
  localparam int RST_EFF_TUNE = (ahist_pkg::RST_TUNE > TUNE_DEPTH) ? TUNE_DEPTH
                                                                   : ahist_pkg::RST_TUNE;
  localparam logic [31:0] DEPTH32 = 32'(TUNE_DEPTH);

  // Configuration registers.
  logic [6:0]         bucket_r;
  logic [13:0]        tune_r;
  logic signed [31:0] lower_r;
  logic signed [31:0] upper_r;

  // Statistics and ranging state.
  logic [31:0]        below_r, above_r, count_r;
  logic signed [31:0] min_r, max_r;
  logic signed [63:0] sum_r;
  logic signed [31:0] base_r;
  logic [32:0]        width_r;
  logic               tuning_r;

  // Working registers.
  logic [1:0]         op_r;
  logic signed [31:0] v_r;
  logic signed [31:0] bnd_lo_r;
  logic [HAW-1:0]     hist_idx_r;
  logic [BAW-1:0]     bin_addr_r;
  logic [MAX_BINS-1:0] bin_vld_r;
  logic               rd_vld_r;
  logic               out_valid_r;
  ahist_pkg::out_word_t out_data_r;

  // Derived values.
  logic [6:0]         eff_bins;
  logic [31:0]        eff_tune;
  logic [31:0]        hist_limit;
  logic signed [33:0] lo34, hi34, span34;
  logic [32:0]        span33;
  logic [32:0]        off33, mag33;
  logic [32:0]        div_dividend, div_divisor;
  logic               div_done;
  logic [32:0]        div_q;
  logic [31:0]        bin_rd_data, bin_cur, hist_rd_data;
  logic               hist_we;
  logic               dump_last;
  logic               out_free;

  always_comb begin
    if (bucket_r == 7'd0) begin
      eff_bins = 7'd1;
    end else if (bucket_r > 7'(MAX_BINS)) begin
      eff_bins = 7'(MAX_BINS);
    end else begin
      eff_bins = bucket_r;
    end
    eff_tune   = ({18'd0, tune_r} > DEPTH32) ? DEPTH32 : {18'd0, tune_r};
    hist_limit = (count_r < DEPTH32) ? count_r : DEPTH32;
  end

  // Bounds: span of the range, clamped at zero, to be divided by the bin count.
  always_comb begin
    if (cmd.bnd_start_cfg) begin
      lo34 = 34'(lower_r);
      hi34 = 34'(upper_r);
    end else begin
      lo34 = 34'(min_r);
      hi34 = 34'(max_r) + 34'sd1;
    end
    span34 = hi34 - lo34;
    span33 = span34[33] ? 33'd0 : span34[32:0];
  end

  // Offset of the sample from the base and the below-range check.
  assign off33 = {v_r[31], v_r} - {base_r[31], base_r};
  assign mag33 = 33'd0 - off33;

  // Divider shared by bound setting and bin lookup.
  assign div_dividend = cmd.div_start_bin ? off33 : span33;
  assign div_divisor  = cmd.div_start_bin ? width_r : {26'd0, eff_bins};

  ahist_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start_bin || cmd.bnd_start_cfg || cmd.bnd_start_tune),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  // History store, written while tuning.
  assign hist_we = cmd.take && (in_data.op == ahist_pkg::OP_ADD) && tuning_r
                && (count_r < DEPTH32);

  ahist_ram #(.WIDTH(32), .DEPTH(TUNE_DEPTH)) u_hist_ram (
    .clk     (clk),
    .wr_en   (hist_we),
    .wr_addr (count_r[HAW-1:0]),
    .wr_data (in_data.sample),
    .rd_addr (hist_idx_r),
    .rd_data (hist_rd_data)
  );

  // Bin store; an entry without its valid bit reads as zero.
  assign bin_cur = rd_vld_r ? bin_rd_data : 32'd0;

  ahist_ram #(.WIDTH(32), .DEPTH(MAX_BINS)) u_bin_ram (
    .clk     (clk),
    .wr_en   (cmd.bin_write),
    .wr_addr (bin_addr_r),
    .wr_data (bin_cur + 32'd1),
    .rd_addr (bin_addr_r),
    .rd_data (bin_rd_data)
  );

  assign dump_last = (7'(bin_addr_r) == eff_bins - 7'd1);
  assign out_free  = !out_valid_r || !out_stall;

  // Status word.
  always_comb begin
    stat            = '0;
    stat.op         = op_r;
    stat.tuning     = tuning_r;
    stat.tune_hit   = (count_r >= eff_tune);
    stat.hist_empty = (hist_limit == 32'd0);
    stat.hist_last  = (32'(hist_idx_r) + 32'd1 >= hist_limit);
    stat.off_neg    = off33[32];
    stat.neg_below  = (mag33 >= width_r);
    stat.div_done   = div_done;
    stat.q_over     = (div_q >= {26'd0, eff_bins});
    stat.dump_last  = dump_last;
    stat.out_free   = out_free;
  end

  // Configuration, statistics and ranging state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bucket_r  <= 7'(ahist_pkg::RST_BUCKETS);
      tune_r    <= 14'(ahist_pkg::RST_TUNE);
      lower_r   <= 32'(ahist_pkg::RST_LOWER);
      upper_r   <= 32'(ahist_pkg::RST_UPPER);
      below_r   <= '0;
      above_r   <= '0;
      count_r   <= '0;
      min_r     <= '0;
      max_r     <= '0;
      sum_r     <= '0;
      base_r    <= 32'(ahist_pkg::RST_LOWER);
      width_r   <= 33'(RST_WIDTH);
      tuning_r  <= (RST_EFF_TUNE != 0);
      bin_vld_r <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          ahist_pkg::REG_BUCKETS: bucket_r <= cfg_data[6:0];
          ahist_pkg::REG_TUNE:    tune_r   <= cfg_data[13:0];
          ahist_pkg::REG_LOWER:   lower_r  <= cfg_data;
          ahist_pkg::REG_UPPER:   upper_r  <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.reinit) begin
        below_r   <= '0;
        above_r   <= '0;
        count_r   <= '0;
        min_r     <= '0;
        max_r     <= '0;
        sum_r     <= '0;
        tuning_r  <= (eff_tune != 32'd0);
        bin_vld_r <= '0;
      end
      if (cmd.take && in_data.op == ahist_pkg::OP_ADD) begin
        if (count_r == 32'd0) begin
          min_r <= in_data.sample;
          max_r <= in_data.sample;
        end else begin
          if (in_data.sample > max_r) max_r <= in_data.sample;
          if (in_data.sample < min_r) min_r <= in_data.sample;
        end
        count_r <= count_r + 32'd1;
        sum_r   <= sum_r + 64'(in_data.sample);
      end
      if (cmd.take && in_data.op == ahist_pkg::OP_CLEAR) begin
        below_r   <= '0;
        above_r   <= '0;
        count_r   <= '0;
        sum_r     <= '0;
        bin_vld_r <= '0;
      end
      if (cmd.bnd_load) begin
        base_r  <= bnd_lo_r;
        width_r <= div_q + 33'd1;
      end
      if (cmd.below_inc) below_r <= below_r + 32'd1;
      if (cmd.above_inc) above_r <= above_r + 32'd1;
      if (cmd.bin_write) bin_vld_r[bin_addr_r] <= 1'b1;
      if (cmd.bins_clear) bin_vld_r <= '0;
      if (cmd.tune_end) tuning_r <= 1'b0;
    end
  end

  // Working registers without reset.
  always_ff @(posedge clk) begin
    rd_vld_r <= bin_vld_r[bin_addr_r];
    if (cmd.take) begin
      op_r <= in_data.op;
      v_r  <= in_data.sample;
    end
    if (cmd.load_v_hist) v_r <= hist_rd_data;
    if (cmd.bnd_start_cfg || cmd.bnd_start_tune) bnd_lo_r <= lo34[31:0];
    if (cmd.hist_first) begin
      hist_idx_r <= '0;
    end else if (cmd.hist_next) begin
      hist_idx_r <= hist_idx_r + 1'b1;
    end
    if (cmd.addr_zero || cmd.dump_first) begin
      bin_addr_r <= '0;
    end else if (cmd.addr_q) begin
      bin_addr_r <= div_q[BAW-1:0];
    end else if (cmd.emit) begin
      bin_addr_r <= bin_addr_r + 1'b1;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data_r.bin_index     <= ahist_pkg::BIN_IDX_W'(bin_addr_r);
      out_data_r.bin_hits      <= bin_cur;
      out_data_r.below_hits    <= below_r;
      out_data_r.above_hits    <= above_r;
      out_data_r.least_seen    <= min_r;
      out_data_r.most_seen     <= max_r;
      out_data_r.sample_total  <= sum_r;
      out_data_r.sample_tally  <= count_r;
      out_data_r.range_base    <= base_r;
      out_data_r.bin_span      <= width_r;
      out_data_r.tuning_active <= tuning_r;
      out_data_r.last_item     <= dump_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

### hdl/autoranging_histogram.sv
// Top level of the auto-ranging histogram: controller, datapath and port wiring.
// An add without tuning classifies the sample, using the serial divider to find its bin.
// An add that ends tuning sets the range with the divider, then bins each history entry.
// A dump reads each bin store entry, then emits it; after history binning if tuning.
// A configuration write restarts the statistics and range; clear and op 3 stay in idle.
// Synchronous active-low reset clears counters and bin valid bits at once; no clearing pass.
`default_nettype none

module autoranging_histogram #(
  parameter int MAX_BINS   = ahist_pkg::MAX_BINS_DEF,
  parameter int TUNE_DEPTH = ahist_pkg::TUNE_DEPTH_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire ahist_pkg::in_word_t  in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output ahist_pkg::out_word_t      out_data,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [1:0]           cfg_index,
  input  wire logic [31:0]          cfg_data
);

  ahist_pkg::cmd_t  cmd;
  ahist_pkg::stat_t stat;

  // Sequencing.
  ahist_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_op     (in_data.op),
    .cfg_valid (cfg_valid),
    .stat      (stat),
    .in_stall  (in_stall),
    .cfg_ready (cfg_ready),
    .cmd       (cmd)
  );

  // Arithmetic and storage.
  ahist_dp #(.MAX_BINS(MAX_BINS), .TUNE_DEPTH(TUNE_DEPTH)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

### hdl/ahist_check.sv
// Port-level assertion checker of the histogram, bound to the top level.
`default_nettype none
`include "autoranging_histogram_defines.svh"

module ahist_check (
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 in_valid,
  input wire logic                 in_stall,
  input wire ahist_pkg::in_word_t  in_data,
  input wire logic                 out_valid,
  input wire logic                 out_stall,
  input wire ahist_pkg::out_word_t out_data,
  input wire logic                 cfg_valid,
  input wire logic                 cfg_ready,
  input wire logic [1:0]           cfg_index,
  input wire logic [31:0]          cfg_data
);

  // A stalled result word holds.
  `AH_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "result word changed while stalled")

  // While a dump is part way through, no input word is taken.
  `AH_ASSERT_IMPLY(a_dump_blocks_in, out_valid && !out_data.last_item, in_stall, "input taken during a dump")

  // A register write and an input word never complete together.
  `AH_ASSERT_IMPLY(a_cfg_excl, cfg_valid && cfg_ready, in_stall, "register write alongside an input word")

  // The reported minimum never exceeds the maximum.
  `AH_ASSERT_IMPLY(a_min_max, out_valid, out_data.least_seen <= out_data.most_seen, "minimum above maximum")

endmodule

bind autoranging_histogram ahist_check u_check (.*);

`default_nettype wire
